// File: hw/rtl/mtsf_pkg.sv
`default_nettype none
package mtsf_pkg;

    // defaults for top level parameters
    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH_DEF      = 4;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 28;
    localparam int CFG_IDX_W = 8;
    localparam int CMD_BYTES = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_SECOND = 8'd1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] STRIP_FIRST_RST  = 8'h77;
    localparam logic [BYTE_W-1:0] STRIP_SECOND_RST = 8'h78;

    // status codes
    localparam logic [BYTE_W-1:0] ST_SYSEX      = 8'hf0;
    localparam logic [BYTE_W-1:0] ST_SYSEX_ESC  = 8'hf7;
    localparam logic [BYTE_W-1:0] ST_META       = 8'hff;
    localparam logic [BYTE_W-1:0] ST_SYSTEM     = 8'hf0;
    localparam logic [BYTE_W-1:0] ST_PROGRAM    = 8'hc0;
    localparam logic [BYTE_W-1:0] ST_CH_PRESS   = 8'hd0;
    localparam logic [BYTE_W-1:0] ST_NONE       = 8'h00;
    localparam logic [BYTE_W-1:0] HI_NIBBLE     = 8'hf0;
    localparam logic [BYTE_W-1:0] DATA_MASK     = 8'h7f;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_DELAY   = 3'd0,
        PH_STATUS  = 3'd1,
        PH_MTYPE   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SKIP    = 3'd5
    } phase_t;

    // what one input byte causes: a run of data bytes and an optional tail
    typedef struct packed {
        logic [CMD_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [2:0]                       data_count;
        logic                             tail_en;
        kind_t                            tail_kind;
    } cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/midi_track_meta_strip_filter_unit.sv
`default_nettype none
// track chunk filter: one payload byte is taken per cycle while the command queue has
// room; each byte gives zero to eight results (a re-emitted meta header with a four byte
// length plus a chunk status is the longest), and the back end hands out one result per
// cycle while the output is ready, so the sustained rate is one byte per cycle for plain
// data, and event headers are limited by their result count, with QUEUE_DEPTH commands
// of slack between the parser and the output port; there is no clearing pass after reset
module midi_track_meta_strip_filter_unit
    import mtsf_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input byte requests
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_in_byte,
    input  wire logic                 s_chunk_end,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    // result requests
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [BYTE_W-1:0]         m_out_byte,
    output logic [1:0]                m_out_kind,
    output logic                      m_run_last
);

    // parser to queue
    logic q_push, q_not_full, q_pop, q_not_empty;
    cmd_t push_cmd, head_cmd;

    // front end: parsing, running status, length decoding, strip decision
    mtsf_front #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_byte   (s_in_byte),
        .chunk_end (s_chunk_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_ready   (q_not_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // command queue, one entry per byte that has results
    mtsf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    // back end: expands a command into single results
    mtsf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_not_empty),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_byte  (m_out_byte),
        .out_kind  (m_out_kind),
        .run_last  (m_run_last)
    );

endmodule
`default_nettype wire

// File: hw/rtl/mtsf_front.sv
`default_nettype none
module mtsf_front
    import mtsf_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    in_byte,
    input  wire logic                 chunk_end,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    input  wire logic                 q_ready,
    output logic                      q_push,
    output cmd_t                      q_cmd
);

    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LENGTH_BYTES);

    logic [BYTE_W-1:0] strip_first_reg, strip_second_reg;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] rs_reg, rs_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  lcnt_reg, lcnt_next;
    logic [LEN_W-1:0]  prem_reg, prem_next;
    logic [BYTE_W-1:0] mtype_reg, mtype_next;
    logic              drop_reg, drop_next;
    logic              verb_reg, verb_next;

    logic              accept;
    logic              err;
    logic              swallow;
    cmd_t              cmd;
    logic [LEN_W-1:0]  acc_new;
    logic [CNT_W-1:0]  lcnt_new;
    logic [2:0]        vlq_n;
    logic [3:0][BYTE_W-1:0] vlq_b;
    logic [BYTE_W-1:0] hi;

    // minimal variable length encoding, most significant group first
    always_comb begin
        vlq_n = 3'd1;
        if (acc_new >= LEN_W'(32'h80))     vlq_n = 3'd2;
        if (acc_new >= LEN_W'(32'h4000))   vlq_n = 3'd3;
        if (acc_new >= LEN_W'(32'h200000)) vlq_n = 3'd4;
        vlq_b = '0;
        case (vlq_n)
            3'd1: begin
                vlq_b[0] = {1'b0, acc_new[6:0]};
            end
            3'd2: begin
                vlq_b[0] = {1'b1, acc_new[13:7]};
                vlq_b[1] = {1'b0, acc_new[6:0]};
            end
            3'd3: begin
                vlq_b[0] = {1'b1, acc_new[20:14]};
                vlq_b[1] = {1'b1, acc_new[13:7]};
                vlq_b[2] = {1'b0, acc_new[6:0]};
            end
            default: begin
                vlq_b[0] = {1'b1, acc_new[27:21]};
                vlq_b[1] = {1'b1, acc_new[20:14]};
                vlq_b[2] = {1'b1, acc_new[13:7]};
                vlq_b[3] = {1'b0, acc_new[6:0]};
            end
        endcase
    end

    assign acc_new  = {acc_reg[LEN_W-8:0], in_byte[6:0]};
    assign lcnt_new = lcnt_reg + CNT_W'(1);
    assign accept   = in_valid && in_ready;
    assign in_ready = q_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        phase_next = phase_reg;
        rs_next    = rs_reg;
        acc_next   = acc_reg;
        lcnt_next  = lcnt_reg;
        prem_next  = prem_reg;
        mtype_next = mtype_reg;
        drop_next  = drop_reg;
        verb_next  = verb_reg;
        cmd        = '0;
        cmd.tail_kind = KIND_DATA;
        err        = 1'b0;
        swallow    = 1'b0;
        hi         = '0;

        if (verb_reg) begin
            cmd.bytes[0] = in_byte;
            cmd.data_count = 3'd1;
        end else begin
            case (phase_reg)
                PH_DELAY: begin
                    if (in_byte != 8'd0) begin
                        verb_next = 1'b1;
                        cmd.bytes[0] = in_byte;
                        cmd.data_count = 3'd1;
                    end else begin
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (in_byte[7]) begin
                        if (in_byte == ST_SYSEX || in_byte == ST_SYSEX_ESC) begin
                            rs_next    = in_byte;
                            acc_next   = '0;
                            lcnt_next  = '0;
                            phase_next = PH_LENGTH;
                        end else if (in_byte == ST_META) begin
                            rs_next    = ST_META;
                            phase_next = PH_MTYPE;
                        end else if (in_byte >= ST_SYSTEM) begin
                            err = 1'b1;
                        end else begin
                            hi = in_byte & HI_NIBBLE;
                            rs_next = in_byte;
                            prem_next = (hi == ST_PROGRAM || hi == ST_CH_PRESS) ?
                                        LEN_W'(1) : LEN_W'(2);
                            drop_next = 1'b0;
                            cmd.bytes[0] = 8'd0;
                            cmd.bytes[1] = in_byte;
                            cmd.data_count = 3'd2;
                            phase_next = PH_PAYLOAD;
                        end
                    end else if (rs_reg == ST_NONE) begin
                        err = 1'b1;
                    end else begin
                        // running status: one data byte already here
                        hi = rs_reg & HI_NIBBLE;
                        drop_next = 1'b0;
                        cmd.bytes[0] = 8'd0;
                        cmd.bytes[1] = rs_reg;
                        cmd.bytes[2] = in_byte;
                        cmd.data_count = 3'd3;
                        if (hi == ST_PROGRAM || hi == ST_CH_PRESS) begin
                            prem_next  = '0;
                            phase_next = PH_DELAY;
                        end else begin
                            prem_next  = LEN_W'(1);
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_MTYPE: begin
                    mtype_next = in_byte;
                    drop_next  = (in_byte == strip_first_reg) ||
                                 (in_byte == strip_second_reg);
                    acc_next   = '0;
                    lcnt_next  = '0;
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH: begin
                    acc_next  = acc_new;
                    lcnt_next = lcnt_new;
                    if (in_byte[7]) begin
                        if (lcnt_new >= CNT_MAX) err = 1'b1;
                    end else begin
                        if (rs_reg == ST_META) begin
                            if (!drop_reg) begin
                                cmd.bytes[0] = 8'd0;
                                cmd.bytes[1] = ST_META;
                                cmd.bytes[2] = mtype_reg;
                                for (int i = 0; i < 4; i++) begin
                                    cmd.bytes[3+i] = vlq_b[i];
                                end
                                cmd.data_count = vlq_n + 3'd3;
                            end
                        end else begin
                            drop_next = 1'b0;
                            cmd.bytes[0] = 8'd0;
                            cmd.bytes[1] = rs_reg;
                            for (int i = 0; i < 4; i++) begin
                                cmd.bytes[2+i] = vlq_b[i];
                            end
                            cmd.data_count = vlq_n + 3'd2;
                        end
                        prem_next = acc_new;
                        lcnt_next = '0;
                        if (acc_new == '0) begin
                            if (rs_reg >= ST_SYSTEM) rs_next = ST_NONE;
                            phase_next = PH_DELAY;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (!drop_reg) begin
                        cmd.bytes[0] = in_byte;
                        cmd.data_count = 3'd1;
                    end
                    prem_next = prem_reg - LEN_W'(1);
                    if (prem_next == '0) begin
                        if (rs_reg >= ST_SYSTEM) rs_next = ST_NONE;
                        phase_next = PH_DELAY;
                    end
                end
                default: begin
                    swallow = 1'b1;
                end
            endcase
        end

        if (swallow) begin
            cmd.data_count = '0;
        end else if (err) begin
            cmd.tail_en   = 1'b1;
            cmd.tail_kind = KIND_ERROR;
            if (!chunk_end) phase_next = PH_SKIP;
        end else if (chunk_end) begin
            cmd.tail_en   = 1'b1;
            cmd.tail_kind = (verb_next || phase_next == PH_DELAY) ? KIND_DONE : KIND_ERROR;
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.data_count != 3'd0 || cmd.tail_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_first_reg  <= STRIP_FIRST_RST;
            strip_second_reg <= STRIP_SECOND_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_STRIP_FIRST)  strip_first_reg  <= cfg_data;
            if (cfg_index == CFG_STRIP_SECOND) strip_second_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DELAY;
            rs_reg    <= '0;
            acc_reg   <= '0;
            lcnt_reg  <= '0;
            prem_reg  <= '0;
            mtype_reg <= '0;
            drop_reg  <= 1'b0;
            verb_reg  <= 1'b0;
        end else if (accept) begin
            if (chunk_end) begin
                phase_reg <= PH_DELAY;
                rs_reg    <= '0;
                acc_reg   <= '0;
                lcnt_reg  <= '0;
                prem_reg  <= '0;
                mtype_reg <= '0;
                drop_reg  <= 1'b0;
                verb_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                rs_reg    <= rs_next;
                acc_reg   <= acc_next;
                lcnt_reg  <= lcnt_next;
                prem_reg  <= prem_next;
                mtype_reg <= mtype_next;
                drop_reg  <= drop_next;
                verb_reg  <= verb_next;
            end
        end
    end

    // verbatim copying never meets a parse error
    a_verb_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        verb_reg |-> !err && !swallow)
        else $error("parse error while copying verbatim");

    // the length counter never passes its limit
    a_lcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lcnt_reg <= CNT_MAX)
        else $error("length byte count out of range");

    // a dropped channel event cannot exist
    a_drop_meta: assert property (@(posedge aclk) disable iff (!aresetn)
        (drop_reg && phase_reg == PH_PAYLOAD) |-> rs_reg == ST_META)
        else $error("drop flag set outside a meta event");

endmodule
`default_nettype wire

// File: hw/rtl/mtsf_queue.sv
`default_nettype none
module mtsf_queue
    import mtsf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      not_full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_full  = count_reg != CNT_FULL;
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)      count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push) count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule
`default_nettype wire

// File: hw/rtl/mtsf_back.sv
`default_nettype none
module mtsf_back
    import mtsf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire cmd_t               q_head,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [BYTE_W-1:0]       out_byte,
    output logic [1:0]              out_kind,
    output logic                    run_last
);

    logic [2:0] idx_reg;
    logic [3:0] total;
    logic       is_data;
    logic       is_last;

    assign total   = {1'b0, q_head.data_count} + {3'b000, q_head.tail_en};
    assign is_data = idx_reg < q_head.data_count;
    assign is_last = ({1'b0, idx_reg} + 4'd1) == total;

    assign out_valid = q_valid;
    assign out_byte  = is_data ? q_head.bytes[idx_reg] : 8'd0;
    assign out_kind  = is_data ? KIND_DATA : q_head.tail_kind;
    assign run_last  = is_last;
    assign q_pop     = out_valid && out_ready && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (out_valid && out_ready) begin
            idx_reg <= is_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    a_nonempty_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> total != 4'd0 && {1'b0, idx_reg} < total)
        else $error("result index beyond command");

endmodule
`default_nettype wire

// File: test/midi_track_meta_strip_filter_checker.sv
module midi_track_meta_strip_filter_checker
    import mtsf_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_in_byte,
    input  logic                 s_chunk_end,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [BYTE_W-1:0]    m_out_byte,
    input  logic [1:0]           m_out_kind,
    input  logic                 m_run_last,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        kind_t             kind;
        logic              last;
    } track_res_t;

    track_res_t filtered_track_q[$];
    track_res_t byte_results[$];

    logic [BYTE_W-1:0] strip_first;
    logic [BYTE_W-1:0] strip_second;
    phase_t            phase;
    logic [BYTE_W-1:0] running_st;
    logic [LEN_W-1:0]  len_acc;
    logic [2:0]        len_count;
    logic [LEN_W-1:0]  remaining;
    logic [BYTE_W-1:0] meta_type;
    logic              dropping;
    logic              verbatim;
    int                mismatches;

    function automatic logic [LEN_W-1:0] channel_data_len(input logic [BYTE_W-1:0] st);
        if ((st & HI_NIBBLE) == ST_PROGRAM || (st & HI_NIBBLE) == ST_CH_PRESS) begin
            return 1;
        end
        return 2;
    endfunction

    task automatic clear_chunk();
        phase      = PH_DELAY;
        running_st = ST_NONE;
        len_acc    = '0;
        len_count  = '0;
        remaining  = '0;
        meta_type  = '0;
        dropping   = 1'b0;
        verbatim   = 1'b0;
    endtask

    task automatic end_event();
        if (running_st >= ST_SYSTEM) begin
            running_st = ST_NONE;
        end
        phase = PH_DELAY;
    endtask

    task automatic emit(input logic [BYTE_W-1:0] b, input kind_t k);
        track_res_t r;
        r.out_byte = b;
        r.kind     = k;
        r.last     = 1'b0;
        byte_results.push_back(r);
    endtask

    // minimal variable length quantity, most significant group first
    task automatic emit_vlq(input logic [LEN_W-1:0] v);
        int groups;
        int g;
        logic [BYTE_W-1:0] part;
        groups = 1;
        if (v >= 28'h80) groups = 2;
        if (v >= 28'h4000) groups = 3;
        if (v >= 28'h200000) groups = 4;
        for (g = groups - 1; g >= 0; g--) begin
            part = {1'b0, v[7*g +: 7]};
            if (g > 0) part[7] = 1'b1;
            emit(part, KIND_DATA);
        end
    endtask

    // results that one track byte causes, queued in order
    task automatic filter_track_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic bad;
        logic swallow;
        int i;
        track_res_t r;
        bad     = 1'b0;
        swallow = 1'b0;
        byte_results.delete();
        if (verbatim) begin
            emit(b, KIND_DATA);
        end else begin
            case (phase)
                PH_DELAY: begin
                    if (b != 8'h00) begin
                        verbatim = 1'b1;
                        emit(b, KIND_DATA);
                    end else begin
                        phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (b[7]) begin
                        if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                            running_st = b;
                            len_acc    = '0;
                            len_count  = '0;
                            phase      = PH_LENGTH;
                        end else if (b == ST_META) begin
                            running_st = b;
                            phase      = PH_MTYPE;
                        end else if (b >= ST_SYSTEM) begin
                            bad = 1'b1;
                        end else begin
                            running_st = b;
                            remaining  = channel_data_len(b);
                            dropping   = 1'b0;
                            emit(8'h00, KIND_DATA);
                            emit(b, KIND_DATA);
                            phase = PH_PAYLOAD;
                        end
                    end else if (running_st == ST_NONE) begin
                        bad = 1'b1;
                    end else begin
                        dropping = 1'b0;
                        emit(8'h00, KIND_DATA);
                        emit(running_st, KIND_DATA);
                        emit(b, KIND_DATA);
                        remaining = channel_data_len(running_st) - 1;
                        if (remaining == 0) end_event();
                        else phase = PH_PAYLOAD;
                    end
                end
                PH_MTYPE: begin
                    meta_type = b;
                    dropping  = (b == strip_first) || (b == strip_second);
                    len_acc   = '0;
                    len_count = '0;
                    phase     = PH_LENGTH;
                end
                PH_LENGTH: begin
                    len_acc   = {len_acc[LEN_W-8:0], b[6:0]};
                    len_count = len_count + 3'd1;
                    if (b[7]) begin
                        if (len_count >= MAX_LENGTH_BYTES) bad = 1'b1;
                    end else begin
                        if (running_st == ST_META) begin
                            if (!dropping) begin
                                emit(8'h00, KIND_DATA);
                                emit(ST_META, KIND_DATA);
                                emit(meta_type, KIND_DATA);
                                emit_vlq(len_acc);
                            end
                        end else begin
                            dropping = 1'b0;
                            emit(8'h00, KIND_DATA);
                            emit(running_st, KIND_DATA);
                            emit_vlq(len_acc);
                        end
                        remaining = len_acc;
                        len_count = '0;
                        if (remaining == 0) end_event();
                        else phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (!dropping) emit(b, KIND_DATA);
                    remaining = remaining - 1;
                    if (remaining == 0) end_event();
                end
                default: begin
                    // rest of a malformed chunk goes nowhere
                    swallow = 1'b1;
                    if (fin) clear_chunk();
                end
            endcase
        end

        if (!swallow) begin
            if (bad) begin
                emit(8'h00, KIND_ERROR);
                if (fin) clear_chunk();
                else phase = PH_SKIP;
            end else if (fin) begin
                if (verbatim || phase == PH_DELAY) emit(8'h00, KIND_DONE);
                else emit(8'h00, KIND_ERROR);
                clear_chunk();
            end
        end

        for (i = 0; i < byte_results.size(); i++) begin
            r      = byte_results[i];
            r.last = (i == byte_results.size() - 1);
            filtered_track_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin : watch
        track_res_t want;
        if (!aresetn) begin
            strip_first  = STRIP_FIRST_RST;
            strip_second = STRIP_SECOND_RST;
            clear_chunk();
            filtered_track_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STRIP_FIRST:  strip_first = cfg_data;
                    CFG_STRIP_SECOND: strip_second = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                filter_track_byte(s_in_byte, s_chunk_end);
            end
            if (m_valid && m_ready) begin
                if (filtered_track_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected result byte %02h kind %0d last %0b",
                                 $time, m_out_byte, m_out_kind, m_run_last);
                    end
                    mismatches++;
                end else begin
                    want = filtered_track_q.pop_front();
                    if (m_out_byte !== want.out_byte || m_out_kind !== want.kind
                            || m_run_last !== want.last) begin
                        if (mismatches < 10) begin
                            $display("%0t: result byte %02h kind %0d last %0b, expected %02h %0d %0b",
                                     $time, m_out_byte, m_out_kind, m_run_last,
                                     want.out_byte, want.kind, want.last);
                        end
                        mismatches++;
                    end
                end
            end
            fail_count <= mismatches;
            pending    <= filtered_track_q.size();
        end
    end

endmodule

// File: test/testbench.sv
module testbench;
    import mtsf_pkg::*;

    // longest quiet stretch tolerated, far above stall plus queue drain
    localparam int LIMIT        = 2000;
    // cycles allowed for bytes that give no result to leave the block
    localparam int DRAIN_CYCLES = 16;
    // end of track meta type, a common real-world event
    localparam logic [BYTE_W-1:0] META_END_OF_TRACK = 8'h2f;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_in_byte   = '0;
    logic                 s_chunk_end = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [BYTE_W-1:0]    cfg_data    = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [BYTE_W-1:0]    m_out_byte;
    logic [1:0]           m_out_kind;
    logic                 m_run_last;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int sent         = 0;

    // stretches of back-to-back requests on either side
    logic s_burst = 1'b0;
    logic m_burst = 1'b0;

    // generator view of the chunk being built
    logic [BYTE_W-1:0] chunk[$];
    int                rs_len;
    logic [BYTE_W-1:0] cur_strip_first  = STRIP_FIRST_RST;
    logic [BYTE_W-1:0] cur_strip_second = STRIP_SECOND_RST;

    always #5 aclk = ~aclk;

    midi_track_meta_strip_filter_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_chunk_end (s_chunk_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_kind  (m_out_kind),
        .m_run_last  (m_run_last)
    );

    // predicts, compares and counts failures on its own
    midi_track_meta_strip_filter_checker #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES_DEF)
    ) track_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_chunk_end (s_chunk_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_kind  (m_out_kind),
        .m_run_last  (m_run_last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // watchdog: any accepted request on any channel resets the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stall before each request, bursts with none
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = m_burst ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 47) == 0) m_burst = !m_burst;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // one byte request; valid stays up when the next byte follows at once
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last_byte);
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 47) == 0) s_burst = !s_burst;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_byte   <= b;
        s_chunk_end <= last_byte;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_chunk();
        int i;
        for (i = 0; i < chunk.size(); i++) begin
            send_byte(chunk[i], i == chunk.size() - 1);
        end
    endtask

    // idle point: every expected result in, then some slack for silent bytes
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // length field, sometimes padded with empty leading groups
    task automatic push_len(input logic [LEN_W-1:0] len);
        int groups;
        int pad;
        int g;
        logic [BYTE_W-1:0] part;
        groups = 1;
        if (len >= 28'h80) groups = 2;
        if (len >= 28'h4000) groups = 3;
        if (len >= 28'h200000) groups = 4;
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4 - groups) : 0;
        repeat (pad) chunk.push_back(8'h80);
        for (g = groups - 1; g >= 0; g--) begin
            part = {1'b0, len[7*g +: 7]};
            if (g > 0) part[7] = 1'b1;
            chunk.push_back(part);
        end
    endtask

    // chunks of mostly well-formed events with random content
    task automatic random_phase(input int n_items);
        int target;
        int n_ev;
        int i;
        int n;
        int sel;
        logic stop;
        logic [BYTE_W-1:0] b;
        logic [LEN_W-1:0] len;
        target = sent + n_items;
        while (sent < target) begin
            chunk.delete();
            rs_len = 0;
            stop   = 1'b0;
            n_ev   = $urandom_range(0, 6);
            for (i = 0; i < n_ev && !stop; i++) begin
                // every event starts with a zero delay
                chunk.push_back(8'h00);
                if ($urandom_range(0, 11) == 0) begin
                    // event that is usually broken; after a parse error the rest of the chunk is swallowed
                    case ($urandom_range(0, 4))
                        0: begin
                            // bad status
                            b = $urandom_range(8'hf1, 8'hfe);
                            if (b == ST_SYSEX_ESC) b = 8'hf8;
                            chunk.push_back(b);
                        end
                        1: begin
                            // data byte where a status is due
                            chunk.push_back($urandom_range(0, 127));
                        end
                        2: begin
                            // length longer than allowed
                            if ($urandom_range(0, 1)) begin
                                chunk.push_back(ST_META);
                                chunk.push_back($urandom_range(0, 255));
                            end else begin
                                chunk.push_back(ST_SYSEX);
                            end
                            repeat (4) chunk.push_back($urandom_range(128, 255));
                        end
                        3: begin
                            // huge length, chunk ends inside the payload
                            if ($urandom_range(0, 1)) begin
                                chunk.push_back(ST_META);
                                chunk.push_back($urandom_range(0, 255));
                            end else begin
                                chunk.push_back(ST_SYSEX_ESC);
                            end
                            len = $urandom_range(32'h4000, 32'h0fffffff);
                            push_len(len);
                            repeat ($urandom_range(0, 3)) chunk.push_back($urandom_range(0, 255));
                            stop = 1'b1;
                        end
                        default: begin
                            n = $urandom_range(1, 4);
                            repeat (n) chunk.push_back($urandom_range(0, 255));
                        end
                    endcase
                end else begin
                    sel = $urandom_range(0, 9);
                    // running status only once a channel status is held
                    if (sel >= 4 && sel <= 5 && rs_len == 0) sel = 0;
                    case (sel)
                        0, 1, 2, 3: begin
                            b = $urandom_range(8'h80, 8'hef);
                            rs_len = ((b & HI_NIBBLE) == ST_PROGRAM ||
                                      (b & HI_NIBBLE) == ST_CH_PRESS) ? 1 : 2;
                            chunk.push_back(b);
                            repeat (rs_len) chunk.push_back($urandom_range(0, 255));
                        end
                        4, 5: begin
                            chunk.push_back($urandom_range(0, 127));
                            repeat (rs_len - 1) chunk.push_back($urandom_range(0, 255));
                        end
                        6, 7: begin
                            chunk.push_back(ST_META);
                            case ($urandom_range(0, 3))
                                0: b = cur_strip_first;
                                1: b = cur_strip_second;
                                2: b = META_END_OF_TRACK;
                                default: b = $urandom_range(0, 255);
                            endcase
                            chunk.push_back(b);
                            len = ($urandom_range(0, 23) == 0) ? $urandom_range(128, 150)
                                                               : $urandom_range(0, 4);
                            push_len(len);
                            repeat (len) chunk.push_back($urandom_range(0, 255));
                            rs_len = 0;
                        end
                        default: begin
                            chunk.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
                            len = ($urandom_range(0, 23) == 0) ? $urandom_range(128, 150)
                                                               : $urandom_range(0, 4);
                            push_len(len);
                            repeat (len) chunk.push_back($urandom_range(0, 255));
                            rs_len = 0;
                        end
                    endcase
                end
            end
            if (!stop) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        // nonzero delay, verbatim copy to the end
                        chunk.push_back($urandom_range(1, 255));
                        repeat ($urandom_range(0, 6)) chunk.push_back($urandom_range(0, 255));
                    end
                    2: begin
                        // cut the chunk short
                        n = $urandom_range(1, 3);
                        while (n > 0 && chunk.size() > 1) begin
                            void'(chunk.pop_back());
                            n--;
                        end
                    end
                    default: ;
                endcase
            end
            if (chunk.size() == 0) chunk.push_back(8'h00);
            send_chunk();
        end
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] first_vals[4];
        logic [BYTE_W-1:0] second_vals[4];
        int p;
        // register settings, extremes included
        first_vals  = '{8'h00, META_END_OF_TRACK, 8'hff, STRIP_SECOND_RST};
        second_vals = '{8'hff, 8'h51, 8'h00, STRIP_FIRST_RST};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // program change, running status, both stripped types, padded sysex length
        chunk = '{8'h00, ST_PROGRAM | 8'h05, 8'h7f,
                  8'h00, 8'h00,
                  8'h00, ST_META, STRIP_FIRST_RST, 8'h00,
                  8'h00, ST_META, STRIP_SECOND_RST, 8'h01, 8'h55,
                  8'h00, ST_SYSEX_ESC, 8'h80, 8'h01, 8'hff};
        send_chunk();
        // longest meta header then truncation: most results from one byte
        chunk = '{8'h00, ST_META, 8'h01, 8'hff, 8'hff, 8'hff, 8'h7f};
        send_chunk();
        // nonzero delay at the start of a chunk
        chunk = '{8'h05, 8'he0};
        send_chunk();
        // bad status on the final byte
        chunk = '{8'h00, 8'hf4};
        send_chunk();

        random_phase(60);
        for (p = 0; p < 4; p++) begin
            settle();
            write_reg(CFG_STRIP_FIRST, first_vals[p]);
            write_reg(CFG_STRIP_SECOND, second_vals[p]);
            cur_strip_first  = first_vals[p];
            cur_strip_second = second_vals[p];
            random_phase(70);
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
